FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with the reset term kept in the property
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/wps_pkg.sv
package wps_pkg;

    localparam int MAX_WAYPOINTS = 16;
    localparam int SLOT_W        = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W         = 5;
    localparam int CORDIC_STEPS  = 16;
    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_ITERS  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int STEP_W        = $clog2(ATAN_LEN);
    localparam int CX_W          = 36;

    localparam logic [31:0] TURN_GAIN  = 32'd316243071;
    localparam logic [13:0] TURN_LIMIT = 14'd8192;
    localparam logic [12:0] SPEED_ONE  = 13'd4096;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_POSE = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_REPEAT = 2'd0,
        REG_COUNT  = 2'd1,
        REG_RADIUS = 2'd2,
        REG_NONE   = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_SUM,
        S_SQR,
        S_CMP,
        S_CSTART,
        S_CWAIT,
        S_GAIN,
        S_SCALE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic        done;
        logic [31:0] angle;
    } cordic_res_t;

    function automatic logic [31:0] atan_step(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/wps_if.sv
interface wps_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [3:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [15:0] heading;
    modport source (output valid, operation, point_index, coord_x, coord_y, heading,
                    input ready);
    modport sink (input valid, operation, point_index, coord_x, coord_y, heading,
                  output ready);
endinterface

interface wps_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] turn_rate;
    logic [12:0]        forward_speed;
    logic [3:0]         target_slot;
    logic               finished;
    modport source (output valid, turn_rate, forward_speed, target_slot, finished,
                    input ready);
    modport sink (input valid, turn_rate, forward_speed, target_slot, finished,
                  output ready);
endinterface

interface wps_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [30:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/wps_cordic.sv
`include "assert_macros.svh"

module wps_cordic
    import wps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] x_in,
    input  logic signed [32:0] y_in,
    output cordic_res_t        res
);

    logic signed [CX_W-1:0] x_reg;
    logic signed [CX_W-1:0] y_reg;
    logic [31:0]            z_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic                   zero_reg;
    logic signed [CX_W-1:0] x_ext;
    logic signed [CX_W-1:0] y_ext;
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    logic                   last_step;

    assign x_ext     = CX_W'(x_in);
    assign y_ext     = CX_W'(y_in);
    assign xs        = x_reg >>> step_reg;
    assign ys        = y_reg >>> step_reg;
    assign last_step = (step_reg == STEP_W'(CORDIC_ITERS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (last_step)
                    busy_reg <= 1'b0;
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (x_in == '0) && (y_in == '0);
            // left half plane: rotate by half a turn first
            if (x_in < 0)
            begin
                x_reg <= -x_ext;
                y_reg <= -y_ext;
                z_reg <= 32'h8000_0000;
            end
            else
            begin
                x_reg <= x_ext;
                y_reg <= y_ext;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_step(step_reg);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_step(step_reg);
            end
        end
    end

    assign res.done  = done_reg;
    assign res.angle = zero_reg ? 32'd0 : z_reg;

    `ASSERT_CLK(a_done_after_last, busy_reg && last_step && !start |=> done_reg,
                "cordic done missing after last step")
    `ASSERT_CLK(a_done_not_busy, done_reg |-> !busy_reg || $past(start),
                "cordic done while still iterating")

endmodule

FILE: src/waypoint_patrol_steering.sv
// Waypoint patrol steering.
// cmd channel: operation 0 loads a waypoint slot, 1 stores the pose, 2 is a
// control tick; only a tick produces a transaction on rsp.
// cfg channel: index 0 repeat_enable, 1 waypoint_count, 2 arrive_radius;
// always ready; the user must write it only while the block is idle, and the block itself does not enforce this.
// Loads and pose updates are stored at acceptance. A tick with no arrival
// steps through the difference, dx^2, dy^2, the sum, radius^2 and the compare,
// a CORDIC start, the 16 CORDIC steps and done, then gain, scale and the output
// load. The shared 32x32 multiplier is used four times (dx^2, dy^2, radius^2,
// gain). An arrival re-reads the next waypoint and goes straight to the CORDIC
// without a second arrival test. A target too far to test for arrival skips
// to the CORDIC. A finishing tick answers with a stop after the compare; a
// finished block answers with a stop straight from idle.
// cmd.ready is high only in the idle state, also while a result waits on rsp.
// The result sits in an output register; if rsp is stalled the block waits
// there with cmd.ready low until the register frees.
// Reset clears pose, slot, finished flag and config to defaults; the
// waypoint table is not cleared.
`include "assert_macros.svh"

module waypoint_patrol_steering
    import wps_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    wps_cmd_if.sink   cmd,
    wps_rsp_if.source rsp,
    wps_cfg_if.sink   cfg
);

    state_t state_reg, state_next;

    logic signed [31:0] wx_reg [MAX_WAYPOINTS];
    logic signed [31:0] wy_reg [MAX_WAYPOINTS];
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic [15:0]        hd_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               done_reg;
    logic               repeat_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [30:0]        radius_reg;

    logic               adv_reg;
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic [63:0]        d2_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        aerr_reg;
    logic               eneg_reg;
    logic               arrive;
    logic               fin_now;

    logic signed [14:0] res_turn_reg;
    logic [12:0]        res_speed_reg;
    logic               res_fin_reg;

    logic               out_valid_reg;
    logic signed [14:0] out_turn_reg;
    logic [12:0]        out_speed_reg;
    logic [3:0]         out_slot_reg;
    logic               out_fin_reg;

    logic               cmd_fire;
    logic               in_range;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [CNT_W-1:0]   cnt_eff;
    logic [CNT_W-1:0]   next_slot;
    logic               wrap_end;
    logic               cstart;
    cordic_res_t        cres;
    logic [31:0]        diff;
    logic [63:0]        rnd;
    logic [19:0]        mag_raw;
    logic [13:0]        mag;
    logic [15:0]        spd3;
    logic               out_load;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // |dx| < 2^31 and |dy| < 2^31, otherwise never arrived
    assign in_range = (dx_reg[32] == dx_reg[31]) && (dx_reg[31:0] != 32'h8000_0000) &&
                      (dy_reg[32] == dy_reg[31]) && (dy_reg[31:0] != 32'h8000_0000);
    assign adx = dx_reg[31] ? (32'd0 - dx_reg[31:0]) : dx_reg[31:0];
    assign ady = dy_reg[31] ? (32'd0 - dy_reg[31:0]) : dy_reg[31:0];

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            S_SQX:
            begin
                mul_a = adx;
                mul_b = adx;
            end
            S_SQY:
            begin
                mul_a = ady;
                mul_b = ady;
            end
            S_SQR:
            begin
                mul_a = {1'b0, radius_reg};
                mul_b = {1'b0, radius_reg};
            end
            default:
            begin
                mul_a = aerr_reg;
                mul_b = TURN_GAIN;
            end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign cnt_eff = (count_reg == '0) ? CNT_W'(1) :
                     (count_reg > CNT_W'(MAX_WAYPOINTS)) ? CNT_W'(MAX_WAYPOINTS) : count_reg;
    assign next_slot = CNT_W'(slot_reg) + CNT_W'(1);
    assign wrap_end  = (next_slot >= cnt_eff);
    assign arrive    = (d2_reg <= prod_reg);
    assign fin_now   = arrive && wrap_end && !repeat_reg;
    assign cstart    = (state_reg == S_CSTART);

    wps_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cstart),
        .x_in  (dx_reg),
        .y_in  (dy_reg),
        .res   (cres)
    );

    assign diff    = cres.angle - {hd_reg, 16'd0};
    assign rnd     = prod_reg + (64'd1 << 43);
    assign mag_raw = rnd[63:44];
    assign mag     = (mag_raw > 20'(TURN_LIMIT)) ? TURN_LIMIT : mag_raw[13:0];
    assign spd3    = (16'(mag) * 16'd3 + 16'd1) >> 1;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (cmd_fire && cmd.operation == OP_TICK)
                    state_next = done_reg ? S_OUT : S_DIFF;
            S_DIFF:   state_next = adv_reg ? S_CSTART : S_SQX;
            S_SQX:    state_next = in_range ? S_SQY : S_CSTART;
            S_SQY:    state_next = S_SUM;
            S_SUM:    state_next = S_SQR;
            S_SQR:    state_next = S_CMP;
            S_CMP:
                if (fin_now)
                    state_next = S_OUT;
                else if (arrive)
                    state_next = S_DIFF;
                else
                    state_next = S_CSTART;
            S_CSTART: state_next = S_CWAIT;
            S_CWAIT:  if (cres.done) state_next = S_GAIN;
            S_GAIN:   state_next = S_SCALE;
            S_SCALE:  state_next = S_OUT;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            px_reg        <= '0;
            py_reg        <= '0;
            hd_reg        <= '0;
            slot_reg      <= '0;
            done_reg      <= 1'b0;
            repeat_reg    <= 1'b0;
            count_reg     <= CNT_W'(1);
            radius_reg    <= 31'd19661;
            out_valid_reg <= 1'b0;
            adv_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_REPEAT: repeat_reg <= cfg.data[0];
                    REG_COUNT:  count_reg  <= cfg.data[CNT_W-1:0];
                    REG_RADIUS: radius_reg <= cfg.data;
                    default:    ;
                endcase
            end
            if (cmd_fire && cmd.operation == OP_POSE)
            begin
                px_reg <= cmd.coord_x;
                py_reg <= cmd.coord_y;
                hd_reg <= cmd.heading;
            end
            if (cmd_fire)
                adv_reg <= 1'b0;
            if (state_reg == S_CMP && arrive)
            begin
                if (fin_now)
                    done_reg <= 1'b1;
                else
                begin
                    slot_reg <= wrap_end ? '0 : next_slot[SLOT_W-1:0];
                    adv_reg  <= 1'b1;
                end
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire && cmd.operation == OP_LOAD && 32'(cmd.point_index) < MAX_WAYPOINTS)
        begin
            wx_reg[cmd.point_index[SLOT_W-1:0]] <= cmd.coord_x;
            wy_reg[cmd.point_index[SLOT_W-1:0]] <= cmd.coord_y;
        end
        if (state_reg == S_IDLE)
        begin
            res_turn_reg  <= '0;
            res_speed_reg <= '0;
            res_fin_reg   <= 1'b1;
        end
        case (state_reg)
            S_DIFF:
            begin
                dx_reg <= 33'(wx_reg[slot_reg]) - 33'(px_reg);
                dy_reg <= 33'(wy_reg[slot_reg]) - 33'(py_reg);
            end
            S_SQX: d2_reg   <= mul_p;
            S_SQY: prod_reg <= mul_p;
            S_SUM: d2_reg   <= d2_reg + prod_reg;
            S_SQR: prod_reg <= mul_p;
            S_CWAIT:
            begin
                eneg_reg <= diff[31];
                aerr_reg <= diff[31] ? (32'd0 - diff) : diff;
            end
            S_GAIN: prod_reg <= mul_p;
            S_SCALE:
            begin
                res_turn_reg  <= eneg_reg ? (15'd0 - 15'(mag)) : 15'(mag);
                res_speed_reg <= (spd3 >= 16'(SPEED_ONE)) ? 13'd0 : (SPEED_ONE - spd3[12:0]);
                res_fin_reg   <= 1'b0;
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_turn_reg  <= res_turn_reg;
            out_speed_reg <= res_speed_reg;
            out_slot_reg  <= 4'(slot_reg);
            out_fin_reg   <= res_fin_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.turn_rate     = out_turn_reg;
    assign rsp.forward_speed = out_speed_reg;
    assign rsp.target_slot   = out_slot_reg;
    assign rsp.finished      = out_fin_reg;

    `ASSERT_CLK(a_done_sticky, done_reg |=> done_reg, "finished flag cleared without reset")
    `ASSERT_CLK(a_stop_zero, rsp.valid && rsp.finished |-> rsp.turn_rate == 15'd0 &&
                rsp.forward_speed == 13'd0, "stop result carries motion")
    `ASSERT_CLK(a_speed_range, rsp.valid |-> rsp.forward_speed <= SPEED_ONE,
                "forward speed above one")
    `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_reg == S_IDLE && !out_valid_reg,
                   "not idle in reset")

endmodule

FILE: test/testbench.sv
module testbench;
    import wps_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 60;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 130;

    typedef struct packed {
        op_t                op;
        logic [3:0]         slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] hd;
    } command_t;

    typedef struct packed {
        logic signed [14:0] turn;
        logic [12:0]        speed;
        logic [3:0]         slot;
        logic               fin;
    } steer_t;

    class steering_scoreboard;
        logic [31:0] wx[MAX_WAYPOINTS];
        logic [31:0] wy[MAX_WAYPOINTS];
        logic [31:0] px, py;
        logic [15:0] phd;
        logic [3:0]  slot;
        bit          done;
        bit          rep;
        logic [4:0]  cnt;
        logic [30:0] radius;
        steer_t      pending[$];
        int          fails;
        logic [31:0] atan_tbl[16] = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861};

        function new();
            px = 0; py = 0; phd = 0; slot = 0; done = 0;
            rep = 0; cnt = 1; radius = 31'd19661; fails = 0;
        endfunction

        function void write_reg(cfg_reg_t r, logic [30:0] d);
            case (r)
                REG_REPEAT: rep = d[0];
                REG_COUNT:  cnt = d[4:0];
                REG_RADIUS: radius = d;
                default: ;
            endcase
        endfunction

        function logic [31:0] bearing(longint x, longint y);
            logic [31:0] z;
            longint xs, ys;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = 32'h8000_0000;
            end
            for (int i = 0; i < 16; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x += ys; y -= xs; z += atan_tbl[i];
                end
                else
                begin
                    x -= ys; y += xs; z -= atan_tbl[i];
                end
            end
            return z;
        endfunction

        function void expect_result(steer_t s);
            pending = {pending, s};
        endfunction

        function void push_stop();
            steer_t s;
            s = '{turn: 0, speed: 0, slot: slot, fin: 1'b1};
            expect_result(s);
        endfunction

        function void note_command(command_t c);
            int     lim, nxt;
            longint dx, dy, d2, r2, err, mag;
            logic [31:0] diff;
            steer_t s;
            case (c.op)
                OP_LOAD:
                begin
                    wx[c.slot] = c.x;
                    wy[c.slot] = c.y;
                    return;
                end
                OP_POSE:
                begin
                    px = c.x; py = c.y; phd = c.hd;
                    return;
                end
                OP_TICK: ;
                default: return;
            endcase
            if (done)
            begin
                push_stop();
                return;
            end
            lim = (cnt == 0) ? 1 : (cnt > MAX_WAYPOINTS) ? MAX_WAYPOINTS : cnt;
            dx = longint'($signed(wx[slot])) - longint'($signed(px));
            dy = longint'($signed(wy[slot])) - longint'($signed(py));
            if (dx > -64'sd2147483648 && dx < 64'sd2147483648 &&
                dy > -64'sd2147483648 && dy < 64'sd2147483648)
            begin
                d2 = dx * dx + dy * dy;
                r2 = longint'(radius) * longint'(radius);
                if (d2 <= r2)
                begin
                    nxt = slot + 1;
                    if (nxt >= lim)
                    begin
                        if (rep)
                            nxt = 0;
                        else
                        begin
                            done = 1;
                            push_stop();
                            return;
                        end
                    end
                    slot = 4'(nxt);
                    dx = longint'($signed(wx[slot])) - longint'($signed(px));
                    dy = longint'($signed(wy[slot])) - longint'($signed(py));
                end
            end
            diff = bearing(dx, dy) - {phd, 16'h0000};
            err = longint'($signed(diff));
            mag = (err < 0) ? -err : err;
            mag = (mag * longint'(TURN_GAIN) + (64'sd1 << 43)) >>> 44;
            if (mag > longint'(TURN_LIMIT))
                mag = longint'(TURN_LIMIT);
            s.turn = 15'((err < 0) ? -mag : mag);
            mag = (3 * mag + 1) >>> 1;
            s.speed = (mag >= longint'(SPEED_ONE)) ? 13'd0 : 13'(longint'(SPEED_ONE) - mag);
            s.slot = slot;
            s.fin = 1'b0;
            expect_result(s);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            fails++;
        endtask

        task check_result(steer_t got);
            steer_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected response %p", got));
                return;
            end
            want = pending.pop_front();
            if (got.turn !== want.turn)
                report($sformatf("turn_rate %0d, want %0d", got.turn, want.turn));
            if (got.speed !== want.speed)
                report($sformatf("forward_speed %0d, want %0d", got.speed, want.speed));
            if (got.slot !== want.slot)
                report($sformatf("target_slot %0d, want %0d", got.slot, want.slot));
            if (got.fin !== want.fin)
                report($sformatf("finished %0b, want %0b", got.fin, want.fin));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    bit   quiet = 0;
    int   stall_cycles = 0;
    steering_scoreboard sb;

    wps_cmd_if cmd_ch();
    wps_rsp_if rsp_ch();
    wps_cfg_if cfg_ch();

    waypoint_patrol_steering dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // monitor: commands, config writes and responses at the rising edge
    always @(posedge clk)
    begin
        steer_t   got;
        command_t c;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                c = '{op: op_t'(cmd_ch.operation), slot: cmd_ch.point_index,
                      x: cmd_ch.coord_x, y: cmd_ch.coord_y, hd: cmd_ch.heading};
                sb.note_command(c);
            end
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{turn: rsp_ch.turn_rate, speed: rsp_ch.forward_speed,
                        slot: rsp_ch.target_slot, fin: rsp_ch.finished};
                sb.check_result(got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // response side back-pressure
    initial
    begin
        rsp_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready = 0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            rsp_ch.ready = 1;
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
    end

    task send_command(op_t op, logic [3:0] slot, logic [31:0] x, logic [31:0] y,
                      logic [15:0] hd);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            cmd_ch.valid = 0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        cmd_ch.valid = 1;
        cmd_ch.operation = op;
        cmd_ch.point_index = slot;
        cmd_ch.coord_x = x;
        cmd_ch.coord_y = y;
        cmd_ch.heading = hd;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    task write_cfg(cfg_reg_t r, logic [30:0] d);
        cmd_ch.valid = 0;
        cfg_ch.valid = 1;
        cfg_ch.index = r;
        cfg_ch.data = d;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 0;
    endtask

    task drain();
        cmd_ch.valid = 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [31:0] near_coord(logic [31:0] base);
        int span;
        span = (sb.radius > 31'd2000000) ? 1000000 : int'(sb.radius) / 2;
        return base + $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [31:0] any_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    task random_phase(bit rep);
        int n;
        int pick;
        logic [30:0] rad;
        case ($urandom_range(0, 4))
            0:       rad = 0;
            1:       rad = 31'd19661;
            2:       rad = 31'h7FFF_FFFF;
            default: rad = 31'($urandom_range(1000, 400000));
        endcase
        write_cfg(REG_RADIUS, rad);
        case ($urandom_range(0, 5))
            0:       write_cfg(REG_COUNT, 0);
            1:       write_cfg(REG_COUNT, 31);
            2:       write_cfg(REG_COUNT, 16);
            default: write_cfg(REG_COUNT, 31'($urandom_range(1, 16)));
        endcase
        write_cfg(REG_REPEAT, rep);
        n = 0;
        while (n < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_command(OP_LOAD, 4'($urandom), any_coord(), any_coord(), 16'($urandom));
            else if (pick < 45)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_command(OP_POSE, 4'($urandom), near_coord(sb.wx[sb.slot]),
                                 near_coord(sb.wy[sb.slot]), 16'($urandom));
                else
                    send_command(OP_POSE, 4'($urandom), any_coord(), any_coord(),
                                 16'($urandom));
            end
            else if (pick < 96)
                send_command(OP_TICK, 4'($urandom), $urandom, $urandom, 16'($urandom));
            else
            begin
                send_command(OP_NONE, 4'($urandom), $urandom, $urandom, 16'($urandom));
                n--;
            end
            n++;
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        cmd_ch.valid = 0;
        cmd_ch.operation = OP_LOAD;
        cmd_ch.point_index = 0;
        cmd_ch.coord_x = 0;
        cmd_ch.coord_y = 0;
        cmd_ch.heading = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = REG_REPEAT;
        cfg_ch.data = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        write_cfg(REG_COUNT, 16);
        write_cfg(REG_REPEAT, 1);
        write_cfg(REG_RADIUS, 0);
        // extremes in the first slots; slots 2 and 3 coincide for the zero vector
        send_command(OP_LOAD, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_command(OP_LOAD, 1, 32'h8000_0000, 32'h8000_0000, 0);
        send_command(OP_LOAD, 2, 0, 0, 0);
        send_command(OP_LOAD, 3, 0, 0, 0);
        for (int i = 4; i < MAX_WAYPOINTS; i++)
            send_command(OP_LOAD, 4'(i), any_coord(), any_coord(), 0);
        send_command(OP_TICK, 0, 0, 0, 0);
        send_command(OP_POSE, 0, 32'h8000_0000, 32'h8000_0000, 16'h7FFF);
        send_command(OP_TICK, 0, 0, 0, 0);
        send_command(OP_POSE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
        send_command(OP_TICK, 0, 0, 0, 0);
        send_command(OP_TICK, 0, 0, 0, 0);
        send_command(OP_POSE, 0, 0, 0, 16'hFFFF);
        send_command(OP_TICK, 0, 0, 0, 0);
        send_command(OP_NONE, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            quiet = (p >= PHASES - 2);
            random_phase(p != PHASES - 1);
        end

        if (sb.fails == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
